>>> sv/ggnh_pkg.sv
// Shared types and codes for the greedy geographic next-hop block.
`default_nettype none

package ggnh_pkg;

    localparam int COORD_W = 16;
    localparam int ID_W    = 16;
    localparam int STAT_W  = 3;
    localparam int SQ_W    = 32;
    localparam int DIST_W  = SQ_W + 1;

    localparam logic OP_BEACON = 1'b0;
    localparam logic OP_ROUTE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_ADDED     = 3'd0;
    localparam logic [STAT_W-1:0] ST_REFRESHED = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_FORWARDED = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOCLOSER  = 3'd4;

    localparam logic CFG_OWN_X = 1'b0;
    localparam logic CFG_OWN_Y = 1'b1;

    typedef struct packed {
        logic                      valid;
        logic [ID_W-1:0]           id;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } entry_t;

    typedef struct packed {
        logic            found;
        logic [ID_W-1:0] hop;
        logic            hit;
        logic            free;
    } scan_res_t;

endpackage

`default_nettype wire

>>> sv/ggnh_cell.sv
// One neighbor table entry of the rotating ring.
`default_nettype none

module ggnh_cell (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            shift_en,
    input  wire ggnh_pkg::entry_t shift_in,
    input  wire logic            wr_en,
    input  wire ggnh_pkg::entry_t wr_data,
    output ggnh_pkg::entry_t     q
);

    logic                               valid_reg;
    logic [ggnh_pkg::ID_W-1:0]          id_reg;
    logic signed [ggnh_pkg::COORD_W-1:0] x_reg;
    logic signed [ggnh_pkg::COORD_W-1:0] y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (wr_en) begin
            valid_reg <= wr_data.valid;
        end else if (shift_en) begin
            valid_reg <= shift_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            id_reg <= wr_data.id;
            x_reg  <= wr_data.x;
            y_reg  <= wr_data.y;
        end else if (shift_en) begin
            id_reg <= shift_in.id;
            x_reg  <= shift_in.x;
            y_reg  <= shift_in.y;
        end
    end

    assign q.valid = valid_reg;
    assign q.id    = id_reg;
    assign q.x     = x_reg;
    assign q.y     = y_reg;

endmodule

`default_nettype wire

>>> sv/ggnh_scan.sv
// Two-stage distance and selection unit at the head of the ring.
`default_nettype none

module ggnh_scan #(
    parameter int IDX_W = 5
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                in_vld,
    input  wire logic                                in_own,
    input  wire ggnh_pkg::entry_t                    head,
    input  wire logic [IDX_W-1:0]                    in_idx,
    input  wire logic signed [ggnh_pkg::COORD_W-1:0] own_x,
    input  wire logic signed [ggnh_pkg::COORD_W-1:0] own_y,
    input  wire logic signed [ggnh_pkg::COORD_W-1:0] dst_x,
    input  wire logic signed [ggnh_pkg::COORD_W-1:0] dst_y,
    input  wire logic [ggnh_pkg::ID_W-1:0]           key_id,
    output ggnh_pkg::scan_res_t                      res,
    output logic [IDX_W-1:0]                         hit_idx,
    output logic [IDX_W-1:0]                         free_idx
);

    logic signed [ggnh_pkg::COORD_W-1:0] sel_x;
    logic signed [ggnh_pkg::COORD_W-1:0] sel_y;
    logic signed [ggnh_pkg::COORD_W:0]   dx;
    logic signed [ggnh_pkg::COORD_W:0]   dy;
    logic signed [2*ggnh_pkg::COORD_W+1:0] prod_x;
    logic signed [2*ggnh_pkg::COORD_W+1:0] prod_y;

    logic                          a_vld_reg;
    logic                          a_own_reg;
    logic                          a_ent_reg;
    logic                          a_match_reg;
    logic [ggnh_pkg::ID_W-1:0]     a_id_reg;
    logic [IDX_W-1:0]              a_idx_reg;
    logic [ggnh_pkg::SQ_W-1:0]     a_sqx_reg;
    logic [ggnh_pkg::SQ_W-1:0]     a_sqy_reg;

    logic [ggnh_pkg::DIST_W-1:0]   sq_sum;
    logic [ggnh_pkg::DIST_W-1:0]   best_reg;
    logic                          found_reg;
    logic [ggnh_pkg::ID_W-1:0]     hop_reg;
    logic                          hit_reg;
    logic                          free_reg;
    logic [IDX_W-1:0]              hit_idx_reg;
    logic [IDX_W-1:0]              free_idx_reg;

    assign sel_x  = in_own ? own_x : head.x;
    assign sel_y  = in_own ? own_y : head.y;
    assign dx     = {sel_x[ggnh_pkg::COORD_W-1], sel_x} - {dst_x[ggnh_pkg::COORD_W-1], dst_x};
    assign dy     = {sel_y[ggnh_pkg::COORD_W-1], sel_y} - {dst_y[ggnh_pkg::COORD_W-1], dst_y};
    assign prod_x = dx * dx;
    assign prod_y = dy * dy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        a_own_reg   <= in_own;
        a_ent_reg   <= head.valid;
        a_match_reg <= head.valid && (head.id == key_id);
        a_id_reg    <= head.id;
        a_idx_reg   <= in_idx;
        a_sqx_reg   <= prod_x[ggnh_pkg::SQ_W-1:0];
        a_sqy_reg   <= prod_y[ggnh_pkg::SQ_W-1:0];
    end

    assign sq_sum = {1'b0, a_sqx_reg} + {1'b0, a_sqy_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
        end else if (a_vld_reg) begin
            if (a_own_reg) begin
                found_reg <= 1'b0;
                hit_reg   <= 1'b0;
                free_reg  <= 1'b0;
            end else begin
                if (a_ent_reg && (sq_sum < best_reg)) begin
                    found_reg <= 1'b1;
                end
                if (a_match_reg) begin
                    hit_reg <= 1'b1;
                end
                if (!a_ent_reg) begin
                    free_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_vld_reg) begin
            if (a_own_reg) begin
                best_reg <= sq_sum;
            end else begin
                if (a_ent_reg && (sq_sum < best_reg)) begin
                    best_reg <= sq_sum;
                    hop_reg  <= a_id_reg;
                end
                if (a_match_reg && !hit_reg) begin
                    hit_idx_reg <= a_idx_reg;
                end
                if (!a_ent_reg && !free_reg) begin
                    free_idx_reg <= a_idx_reg;
                end
            end
        end
    end

    assign res.found = found_reg;
    assign res.hop   = hop_reg;
    assign res.hit   = hit_reg;
    assign res.free  = free_reg;
    assign hit_idx   = hit_idx_reg;
    assign free_idx  = free_idx_reg;

endmodule

`default_nettype wire

>>> sv/greedy_geographic_next_hop.sv
// Top level of the greedy geographic next-hop selector with its neighbor ring.
//
//   Channel  Ports                                   Direction
//   s_       s_opcode s_node_id s_pos_x s_pos_y      item in
//   m_       m_status m_next_hop                     result out
//   cfg_     cfg_index cfg_data                      register write
//
// Each item passes from acceptance to a loaded result in these steps:
// this node's own distance enters the distance unit, then the ring of cells rotates
// once past the unit, one entry per cycle, and the unit's stages drain.
// New items are accepted only in the idle state, which follows the loaded result.
// Reset clears all valid bits at once and needs no clearing pass.
// A result waiting on m_ready does not block the next item, which waits at its end.
`default_nettype none

module greedy_geographic_next_hop #(
    parameter int MAX_NEIGHBORS = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_opcode,
    input  wire logic [ggnh_pkg::ID_W-1:0]           s_node_id,
    input  wire logic signed [ggnh_pkg::COORD_W-1:0] s_pos_x,
    input  wire logic signed [ggnh_pkg::COORD_W-1:0] s_pos_y,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [ggnh_pkg::STAT_W-1:0]              m_status,
    output logic [ggnh_pkg::ID_W-1:0]                m_next_hop,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic                                cfg_index,
    input  wire logic [ggnh_pkg::COORD_W-1:0]        cfg_data
);

    localparam int IDX_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_NEIGHBORS - 1);

    localparam logic [2:0] FSM_IDLE  = 3'd0;
    localparam logic [2:0] FSM_OWN   = 3'd1;
    localparam logic [2:0] FSM_SCAN  = 3'd2;
    localparam logic [2:0] FSM_DRAIN = 3'd3;
    localparam logic [2:0] FSM_FIN   = 3'd4;

    logic [2:0]                          state_reg;
    logic [2:0]                          state_next;
    logic [IDX_W-1:0]                    cnt_reg;
    logic [IDX_W-1:0]                    cnt_next;

    logic signed [ggnh_pkg::COORD_W-1:0] own_x_reg;
    logic signed [ggnh_pkg::COORD_W-1:0] own_y_reg;

    logic                                op_reg;
    logic [ggnh_pkg::ID_W-1:0]           id_reg;
    logic signed [ggnh_pkg::COORD_W-1:0] px_reg;
    logic signed [ggnh_pkg::COORD_W-1:0] py_reg;

    logic                                m_valid_reg;
    logic [ggnh_pkg::STAT_W-1:0]         m_status_reg;
    logic [ggnh_pkg::ID_W-1:0]           m_next_hop_reg;
    logic [ggnh_pkg::STAT_W-1:0]         status_next;
    logic [ggnh_pkg::ID_W-1:0]           hop_next;

    logic                                finish;
    logic                                tbl_wr;
    logic [IDX_W-1:0]                    wr_idx;
    ggnh_pkg::entry_t                    wr_entry;
    ggnh_pkg::entry_t                    ring [MAX_NEIGHBORS];
    ggnh_pkg::scan_res_t                 scan_res;
    logic [IDX_W-1:0]                    hit_idx;
    logic [IDX_W-1:0]                    free_idx;

    assign s_ready   = (state_reg == FSM_IDLE);
    assign cfg_ready = 1'b1;
    assign finish    = (state_reg == FSM_FIN) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_x_reg <= '0;
            own_y_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                ggnh_pkg::CFG_OWN_X: own_x_reg <= cfg_data;
                ggnh_pkg::CFG_OWN_Y: own_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg <= s_opcode;
            id_reg <= s_node_id;
            px_reg <= s_pos_x;
            py_reg <= s_pos_y;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            FSM_IDLE: begin
                if (s_valid) begin
                    state_next = FSM_OWN;
                end
            end
            FSM_OWN: begin
                state_next = FSM_SCAN;
                cnt_next   = '0;
            end
            FSM_SCAN: begin
                if (cnt_reg == LAST_IDX) begin
                    state_next = FSM_DRAIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            FSM_DRAIN: begin
                state_next = FSM_FIN;
            end
            FSM_FIN: begin
                if (finish) begin
                    state_next = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    for (genvar i = 0; i < MAX_NEIGHBORS; i++) begin : g_cell
        ggnh_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (state_reg == FSM_SCAN),
            .shift_in (ring[(i + 1) % MAX_NEIGHBORS]),
            .wr_en    (tbl_wr && (wr_idx == IDX_W'(i))),
            .wr_data  (wr_entry),
            .q        (ring[i])
        );
    end

    ggnh_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_vld   ((state_reg == FSM_OWN) || (state_reg == FSM_SCAN)),
        .in_own   (state_reg == FSM_OWN),
        .head     (ring[0]),
        .in_idx   (cnt_reg),
        .own_x    (own_x_reg),
        .own_y    (own_y_reg),
        .dst_x    (px_reg),
        .dst_y    (py_reg),
        .key_id   (id_reg),
        .res      (scan_res),
        .hit_idx  (hit_idx),
        .free_idx (free_idx)
    );

    assign wr_entry.valid = 1'b1;
    assign wr_entry.id    = id_reg;
    assign wr_entry.x     = px_reg;
    assign wr_entry.y     = py_reg;

    always_comb begin
        tbl_wr      = 1'b0;
        wr_idx      = hit_idx;
        hop_next    = '0;
        status_next = ggnh_pkg::ST_NOCLOSER;
        if (op_reg == ggnh_pkg::OP_BEACON) begin
            priority if (scan_res.hit) begin
                status_next = ggnh_pkg::ST_REFRESHED;
                tbl_wr      = finish;
            end else if (scan_res.free) begin
                status_next = ggnh_pkg::ST_ADDED;
                wr_idx      = free_idx;
                tbl_wr      = finish;
            end else begin
                status_next = ggnh_pkg::ST_FULL;
            end
        end else if (scan_res.found) begin
            status_next = ggnh_pkg::ST_FORWARDED;
            hop_next    = scan_res.hop;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            m_status_reg   <= status_next;
            m_next_hop_reg <= hop_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_next_hop = m_next_hop_reg;

`ifndef SYNTHESIS
    a_hop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ggnh_pkg::ST_FORWARDED) |-> m_next_hop == '0)
        else $error("next hop is nonzero for a result that was not forwarded");

    a_scan_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FSM_SCAN) && (cnt_reg == LAST_IDX) |=> state_reg == FSM_DRAIN)
        else $error("ring scan did not end after the last entry");

    a_own_first: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == FSM_OWN |=> (state_reg == FSM_SCAN) && (cnt_reg == '0))
        else $error("ring scan did not start at entry zero");

    a_wr_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_wr |-> finish && (op_reg == ggnh_pkg::OP_BEACON))
        else $error("table written outside the end of a beacon item");
`endif

endmodule

`default_nettype wire
